// File: rtl/gauge_display_frame_encoder_assert.svh
// ----------------------------------------------------------------------------
// Gauge display frame encoder assertion macros
// Concurrent checks, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GAUGE_DISPLAY_FRAME_ENCODER_ASSERT_SVH
`define GAUGE_DISPLAY_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define GDE_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define GDE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/gde_pkg.sv
// ----------------------------------------------------------------------------
// gde_pkg
// Shared types, constants and digit helpers for the gauge display encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gde_pkg;

  localparam int NumFrameBytes = 9;
  localparam int CntW          = $clog2(NumFrameBytes + 1);
  localparam int BarLeds       = 24;
  localparam int RpmPerLed     = 250;
  localparam int StatusMax     = 3;

  // Segment positions inside a digit pattern
  localparam int SegA = 7;
  localparam int SegB = 6;
  localparam int SegC = 5;
  localparam int SegD = 4;
  localparam int SegE = 3;
  localparam int SegF = 2;
  localparam int SegG = 1;

  typedef logic [NumFrameBytes-1:0][7:0] gde_frame_t;

  // Encoded frame offered to the serializer
  typedef struct packed {
    logic       valid;
    gde_frame_t bytes;
  } gde_pend_t;

  typedef struct packed {
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } gde_digits_t;

  // Seven-segment pattern, blank for codes above nine
  function automatic logic [7:0] seg7(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'b1111_1100;
      4'd1:    p = 8'b0110_0000;
      4'd2:    p = 8'b1101_1010;
      4'd3:    p = 8'b1111_0010;
      4'd4:    p = 8'b0110_0110;
      4'd5:    p = 8'b1011_0110;
      4'd6:    p = 8'b1011_1110;
      4'd7:    p = 8'b1110_0000;
      4'd8:    p = 8'b1111_1110;
      4'd9:    p = 8'b1111_0110;
      default: p = 8'b0000_0000;
    endcase
    return p;
  endfunction

  // Decimal split of a 10-bit value by reciprocal multiplies:
  // v/100 = (v*41)>>12 holds for v < 1024, r/10 = (r*205)>>11 for r < 100.
  function automatic gde_digits_t split3(input logic [9:0] v);
    gde_digits_t res;
    logic [15:0] p_hun;
    logic [9:0]  rem10;
    logic [6:0]  rem;
    logic [15:0] p_ten;
    logic [6:0]  one7;
    p_hun   = {6'd0, v} * 16'd41;
    res.hun = p_hun[15:12];
    rem10   = v - ({6'd0, res.hun} * 10'd100);
    rem     = rem10[6:0];
    p_ten   = {9'd0, rem} * 16'd205;
    res.ten = p_ten[14:11];
    one7    = rem - ({3'd0, res.ten} * 7'd10);
    res.one = one7[3:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gauge_display_frame_encoder.sv
// ----------------------------------------------------------------------------
// gauge_display_frame_encoder
// Path: an item passes the input register, the frame shift buffer and then
//   the output register, which gives one byte per cycle while out_stall_i is low.
// A new item can be accepted while the previous frame's bytes still stream out.
// Reset: rst_ni asynchronous, active low; empties the input and output stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gauge_display_frame_encoder import gde_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [9:0]  speed_value_i,
  input  wire logic [9:0]  heading_value_i,
  input  wire logic [13:0] engine_rpm_i,
  input  wire logic [7:0]  status_code_i,
  // result channel, nine shift-register bytes per item
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic             is_last_o
);

  // Encoded frame waiting in the encoder's input register, and the
  // serializer's take strobe that frees that register.
  gde_pend_t pend;
  logic      take;

  // Stage 1: input register, decimal split, seven-segment lookup, rpm bar
  // and status LEDs, mapped onto the nine bytes of the shift chain. The
  // register holds while its frame waits for the serializer.
  gde_encoder u_enc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .speed_value_i   (speed_value_i),
    .heading_value_i (heading_value_i),
    .engine_rpm_i    (engine_rpm_i),
    .status_code_i   (status_code_i),
    .take_i          (take),
    .pend_o          (pend)
  );

  // Stage 2: frame shift buffer and output register. A new frame loads in
  // the cycle its predecessor's last byte moves to the output, so the input
  // register is free again while bytes still stream out.
  gde_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_i       (pend),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .is_last_o    (is_last_o)
  );

endmodule

`default_nettype wire

// File: rtl/gde_encoder.sv
// ----------------------------------------------------------------------------
// gde_encoder
// Input register plus digit, bar and status encoding into a nine-byte frame.
// ----------------------------------------------------------------------------
`default_nettype none

module gde_encoder import gde_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [9:0]  speed_value_i,
  input  wire logic [9:0]  heading_value_i,
  input  wire logic [13:0] engine_rpm_i,
  input  wire logic [7:0]  status_code_i,
  input  wire logic        take_i,
  output gde_pend_t        pend_o
);

  logic        valid_q, valid_d;
  logic [9:0]  speed_q, heading_q;
  logic [13:0] rpm_q;
  logic [7:0]  status_q;
  logic        accept;

  gde_digits_t         sd, hd;
  logic [7:0]          sc, st, su, hc, ht, hu;
  logic [BarLeds-1:0]  bar;
  logic                green, red;
  gde_frame_t          frame;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      speed_q   <= speed_value_i;
      heading_q <= heading_value_i;
      rpm_q     <= engine_rpm_i;
      status_q  <= status_code_i;
    end
  end

  assign sd = split3(speed_q);
  assign hd = split3(heading_q);
  assign sc = seg7(sd.hun);
  assign st = seg7(sd.ten);
  assign su = seg7(sd.one);
  assign hc = seg7(hd.hun);
  assign ht = seg7(hd.ten);
  assign hu = seg7(hd.one);

  // Thermometer bar: LED i lit once rpm reaches (i+1) steps
  always_comb begin
    for (int i = 0; i < BarLeds; i++) begin
      bar[i] = (rpm_q >= 14'((i + 1) * RpmPerLed));
    end
  end

  // Codes above yellow show as off
  assign green = (status_q <= 8'(StatusMax)) && status_q[0];
  assign red   = (status_q <= 8'(StatusMax)) && status_q[1];

  // Board wiring of segments and bar LEDs onto the shift chain
  always_comb begin
    frame[0] = {hu[SegF], ht[SegA], hc[SegB], hc[SegG],
                hc[SegE], 1'b0,     ht[SegC], hu[SegD]};
    frame[1] = {hu[SegA], ht[SegB], ht[SegG], hc[SegF],
                hc[SegD], ht[SegE], 1'b0,     hu[SegC]};
    frame[2] = {hu[SegB], hu[SegG], ht[SegF], hc[SegA],
                hc[SegC], ht[SegD], hu[SegE], green};
    frame[3] = {bar[21], bar[18], bar[15], bar[12], bar[11], bar[8], bar[5], bar[2]};
    frame[4] = {bar[22], bar[19], bar[16], bar[13], bar[10], bar[7], bar[4], bar[1]};
    frame[5] = {bar[23], bar[20], bar[17], bar[14], bar[9],  bar[6], bar[3], bar[0]};
    frame[6] = {sc[SegE], sc[SegC], st[SegA], st[SegD],
                red,      su[SegB], su[SegE], st[SegC]};
    frame[7] = {sc[SegF], 1'b0,     sc[SegB], st[SegE],
                su[SegC], su[SegA], su[SegD], st[SegG]};
    frame[8] = {sc[SegA], sc[SegD], sc[SegG], st[SegF],
                su[SegG], su[SegF], 1'b0,     st[SegB]};
  end

  assign pend_o.valid = valid_q;
  assign pend_o.bytes = frame;

endmodule

`default_nettype wire

// File: rtl/gde_serializer.sv
// ----------------------------------------------------------------------------
// gde_serializer
// Frame shift buffer and output register; one byte per cycle while out_stall_i is low, index 8 first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gauge_display_frame_encoder_assert.svh"

module gde_serializer import gde_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire gde_pend_t  pend_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            is_last_o
);

  localparam logic [CntW-1:0] CntFull = CntW'(NumFrameBytes);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntZero = '0;

  gde_frame_t       buf_q, buf_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             out_free, emit, load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = out_free && (cnt_q != CntZero);
  // Reload as the last byte leaves, so frames run back to back
  assign load     = pend_i.valid && ((cnt_q == CntZero) || ((cnt_q == CntOne) && out_free));
  assign take_o   = load;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = pend_i.bytes;
      cnt_d = CntFull;
    end else if (emit) begin
      for (int i = NumFrameBytes - 1; i > 0; i--) begin
        buf_d[i] = buf_q[i-1];
      end
      buf_d[0] = 8'h00;
      cnt_d    = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CntZero;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (emit) begin
      byte_q <= buf_q[NumFrameBytes-1];
      last_q <= (cnt_q == CntOne);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign is_last_o    = last_q;

  `GDE_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CntFull, "byte count out of range")
  `GDE_ASSERT_NEXT(a_load_full, load, cnt_q == CntFull, "frame load did not set full count")
  `GDE_ASSERT_NEXT(a_emit_shows, emit, out_valid_q, "emitted byte not presented")
  `GDE_ASSERT_IMPL(a_last_drained, out_valid_q && last_q,
                   cnt_q == CntZero || cnt_q == CntFull, "last byte shown with bytes pending")

endmodule

`default_nettype wire
